>>> hdl/register_write_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// register write frame deframer assertion macros
// concurrent assertion helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef REGISTER_WRITE_FRAME_DEFRAMER_ASSERT_SVH
`define REGISTER_WRITE_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RWFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rwfd assertion failed");

// next-cycle implication
`define RWFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rwfd assertion failed");

`else

`define RWFD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RWFD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hdl/rwfd_pkg.sv
// ----------------------------------------------------------------------------
// rwfd package
// shared constants and types of the register write frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package rwfd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 16;

   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h55;

   // one decoded register write, hit marks a good checksum
   typedef struct packed {
      logic              hit;
      logic [WORD_W-1:0] write_addr;
      logic [WORD_W-1:0] write_data;
   } rwfd_result_type;

endpackage

`default_nettype wire

>>> hdl/register_write_frame_deframer.sv
// a good checksum byte's write is registered in the output register, or in the skid entry while rsp stalls
// throughput: one byte item per cycle, sustained while rsp keeps up
// the output register plus one skid entry let req keep flowing under rsp stall until a write is parked in the skid
// reset: synchronous, active high; clears frame position, sum, valids, sync byte to 0x55
// the payload bytes are not reset, they are always written before use
// ----------------------------------------------------------------------------
// register write frame deframer
// turns sync-led six byte frames into 16-bit register writes
// ----------------------------------------------------------------------------
`default_nettype none
`include "register_write_frame_deframer_assert.svh"

module register_write_frame_deframer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration: sync byte
   input  wire logic                           csr_we,
   input  wire logic [rwfd_pkg::BYTE_W-1:0]    csr_wdata,
   // byte items in
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [7:0]                     req_tdata,   // [7:0] rx_byte
   // register write items out
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [31:0]                    rsp_tdata    // [15:0] write_addr, [31:16] write_data
);
   import rwfd_pkg::*;

   // sync byte register
   logic [BYTE_W-1:0] sync_ff;

   // output register and skid entry
   logic              main_valid_ff, main_valid_in;
   logic [WORD_W-1:0] main_addr_ff, main_addr_in;
   logic [WORD_W-1:0] main_data_ff, main_data_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [WORD_W-1:0] skid_addr_ff, skid_addr_in;
   logic [WORD_W-1:0] skid_data_ff, skid_data_in;

   logic              req_accept;
   logic              rsp_pop;
   logic              push;
   rwfd_result_type   result;

   // ready only while the skid entry is free, so no result can be dropped
   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
      end else if (csr_we) begin
         sync_ff <= csr_wdata;
      end
   end

   // frame state machine
   rwfd_frame_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_tdata[BYTE_W-1:0]),
      .sync_byte (sync_ff),
      .result    (result)
   );

   assign push = req_accept && result.hit;

   // output register with one skid entry behind it
   always_comb begin
      main_valid_in = main_valid_ff;
      main_addr_in  = main_addr_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_addr_in  = skid_addr_ff;
      skid_data_in  = skid_data_ff;
      priority if (!main_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            // skid drains first, req is stalled so nothing new arrives
            main_valid_in = 1'b1;
            main_addr_in  = skid_addr_ff;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_addr_in  = result.write_addr;
            main_data_in  = result.write_data;
         end
      end else if (push) begin
         // output held, park the new write
         skid_valid_in = 1'b1;
         skid_addr_in  = result.write_addr;
         skid_data_in  = result.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_addr_ff <= main_addr_in;
      main_data_ff <= main_data_in;
      skid_addr_ff <= skid_addr_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {main_data_ff, main_addr_ff};

   // skid only ever fills behind a full output register
   `RWFD_ASSERT_IMPLY(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   // a write produced under stall lands in the skid entry
   `RWFD_ASSERT_NEXT(a_stall_parks, clock, reset, main_valid_ff && !rsp_tready && push, skid_valid_ff)
   // draining with a full skid keeps the output valid
   `RWFD_ASSERT_NEXT(a_skid_drain, clock, reset, skid_valid_ff && rsp_tready, rsp_tvalid)

endmodule

`default_nettype wire

>>> hdl/rwfd_frame_parser.sv
// ----------------------------------------------------------------------------
// rwfd frame parser
// sync hunt, payload capture and checksum test, one byte per cycle while accept is high
// ----------------------------------------------------------------------------
`default_nettype none

module rwfd_frame_parser (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [rwfd_pkg::BYTE_W-1:0]  rx_byte,
   input  wire logic [rwfd_pkg::BYTE_W-1:0]  sync_byte,
   output rwfd_pkg::rwfd_result_type         result
);
   import rwfd_pkg::*;

   localparam logic [2:0] POS_HUNT  = 3'd0;
   localparam logic [2:0] POS_ADDRH = 3'd1;
   localparam logic [2:0] POS_ADDRL = 3'd2;
   localparam logic [2:0] POS_DATAH = 3'd3;
   localparam logic [2:0] POS_DATAL = 3'd4;
   localparam logic [2:0] POS_CHECK = 3'd5;

   logic [2:0]        pos_ff, pos_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] payload_ff [4];
   logic [1:0]        slot;
   logic              is_sync;

   assign is_sync = (rx_byte == sync_byte);
   assign slot    = pos_ff[1:0] - 2'd1;

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      result.hit        = 1'b0;
      result.write_addr = {payload_ff[0], payload_ff[1]};
      result.write_data = {payload_ff[2], payload_ff[3]};
      unique case (pos_ff)
         POS_ADDRH, POS_ADDRL, POS_DATAH, POS_DATAL: begin
            pos_in = pos_ff + 3'd1;
            sum_in = sum_ff + rx_byte;
         end
         POS_CHECK: begin
            result.hit = (sum_ff == rx_byte);
            // a checksum equal to sync opens the next frame
            if (is_sync) begin
               pos_in = POS_ADDRH;
               sum_in = sync_byte;
            end else begin
               pos_in = POS_HUNT;
               sum_in = '0;
            end
         end
         default: begin
            // hunt, unused codes act the same
            if (is_sync) begin
               pos_in = POS_ADDRH;
               sum_in = sync_byte;
            end else begin
               pos_in = POS_HUNT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         sum_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // payload store, no reset
   always_ff @(posedge clock) begin
      if (accept && (pos_ff >= POS_ADDRH) && (pos_ff <= POS_DATAL)) begin
         payload_ff[slot] <= rx_byte;
      end
   end

endmodule

`default_nettype wire
